>>> src/tplv_pkg.sv
package tplv_pkg;

   // patch sum width
   localparam int SUM_BITS = 12;
   // magnitude bits of the pedestal in sixteenths (up to 16736, down to -3952)
   localparam int PED_MAG_BITS = 15;
   // signed width of sum*16 - pedestal*16
   localparam int DIFF_W = ((SUM_BITS + 4 > PED_MAG_BITS) ? SUM_BITS + 4 : PED_MAG_BITS) + 2;
   // scale in sixteenths: at most 255*16
   localparam int SCALE_W = 12;
   // rounding numerator 2*diff + scale, and denominator 2*scale
   localparam int NUM_W = DIFF_W + 1;
   localparam int DEN_W = SCALE_W + 1;
   // quotient bits resolved by the divider
   localparam int QUO_BITS = 6;
   localparam int CMP_W = (NUM_W > DEN_W + QUO_BITS) ? NUM_W : DEN_W + QUO_BITS;

   localparam logic [5:0] LUT_MAX = 6'd62;

   // CSR address map: paddr width and register index
   localparam int CSR_ADDR_W = 5;
   typedef enum logic [2:0] {
      REG_FORMULA  = 3'd0,
      REG_SCALE    = 3'd1,
      REG_PEDESTAL = 3'd2,
      REG_SIGMA    = 3'd3,
      REG_POWERUP  = 3'd4,
      REG_MASKED   = 3'd5,
      REG_SHIFT    = 3'd6,
      REG_UNUSED   = 3'd7
   } reg_index_type;

   // formula codes (anything else is plain)
   localparam logic [1:0] FORMULA_SCALE = 2'd1;
   localparam logic [1:0] FORMULA_PED   = 2'd2;

   typedef struct packed {
      logic [1:0] formula_mode;
      logic [7:0] base_scale;
      logic [9:0] base_pedestal;
      logic [7:0] sigma_threshold;
      logic       powerup_offset_on;
      logic [4:0] masked_towers;
      logic [7:0] pedestal_shift;
   } cfg_type;

   // classified item passed from front to back
   typedef struct packed {
      logic [DIFF_W-2:0]  diff_pos;
      logic [SCALE_W-1:0] scale16;
      logic               zero;
      logic               sat;
   } item_type;

endpackage

>>> src/tplv_csr.sv
module tplv_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [tplv_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready,
   output tplv_pkg::cfg_type                 cfg
);
   import tplv_pkg::*;

   cfg_type       cfg_ff;
   logic          wr_en;
   reg_index_type idx;

   assign idx    = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.formula_mode      <= 2'd0;
         cfg_ff.base_scale        <= 8'd1;
         cfg_ff.base_pedestal     <= 10'd0;
         cfg_ff.sigma_threshold   <= 8'd0;
         cfg_ff.powerup_offset_on <= 1'b0;
         cfg_ff.masked_towers     <= 5'd0;
         cfg_ff.pedestal_shift    <= 8'd0;
      end else if (wr_en) begin
         case (idx)
            REG_FORMULA:  cfg_ff.formula_mode      <= pwdata[1:0];
            REG_SCALE:    cfg_ff.base_scale        <= pwdata[7:0];
            REG_PEDESTAL: cfg_ff.base_pedestal     <= pwdata[9:0];
            REG_SIGMA:    cfg_ff.sigma_threshold   <= pwdata[7:0];
            REG_POWERUP:  cfg_ff.powerup_offset_on <= pwdata[0];
            REG_MASKED:   cfg_ff.masked_towers     <= pwdata[4:0];
            REG_SHIFT:    cfg_ff.pedestal_shift    <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (idx)
         REG_FORMULA:  prdata = {30'd0, cfg_ff.formula_mode};
         REG_SCALE:    prdata = {24'd0, cfg_ff.base_scale};
         REG_PEDESTAL: prdata = {22'd0, cfg_ff.base_pedestal};
         REG_SIGMA:    prdata = {24'd0, cfg_ff.sigma_threshold};
         REG_POWERUP:  prdata = {31'd0, cfg_ff.powerup_offset_on};
         REG_MASKED:   prdata = {27'd0, cfg_ff.masked_towers};
         REG_SHIFT:    prdata = {24'd0, cfg_ff.pedestal_shift};
         default:      prdata = 32'd0;
      endcase
   end

endmodule

>>> src/tplv_front.sv
module tplv_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [tplv_pkg::SUM_BITS-1:0]     req_patch_sum,
   input  tplv_pkg::cfg_type                 cfg,
   output logic                              item_valid,
   output tplv_pkg::item_type                item,
   input  logic                              item_ready
);
   import tplv_pkg::*;

   logic                     valid_ff, valid_in;
   item_type                 item_ff, item_in;
   logic                     take;
   logic [4:0]               masked_sat;
   logic [SCALE_W-1:0]       scale_prod;
   logic [SCALE_W-1:0]       scale16;
   logic signed [8:0]        shift_m8;
   logic signed [5:0]        masked_s;
   logic signed [14:0]       ped_adj;
   logic [DIFF_W-1:0]        ped16;
   logic [DIFF_W-1:0]        sum16;
   logic signed [DIFF_W-1:0] diff16;
   logic signed [DIFF_W-1:0] sigma16;

   // stage holds while the queue is full
   assign busy       = valid_ff & ~item_ready;
   assign take       = start & ~busy;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   // effective scale in sixteenths
   always_comb begin
      masked_sat = (cfg.masked_towers > 5'd16) ? 5'd16 : cfg.masked_towers;
      scale_prod = {4'd0, cfg.base_scale} * {7'd0, 5'd16 - masked_sat};
      if (cfg.formula_mode == FORMULA_SCALE) begin
         scale16 = (masked_sat == 5'd16) ? SCALE_W'(16) : scale_prod;
      end else begin
         scale16 = {cfg.base_scale, 4'd0};
      end
   end

   // effective pedestal and difference, both in sixteenths
   always_comb begin
      shift_m8 = $signed({1'b0, cfg.pedestal_shift}) - 9'sd8;
      masked_s = $signed({1'b0, masked_sat});
      ped_adj  = shift_m8 * masked_s;
      ped16    = {{(DIFF_W-14){1'b0}}, cfg.base_pedestal, 4'd0};
      if (cfg.powerup_offset_on) begin
         ped16 = ped16 + DIFF_W'(240);
      end
      if (cfg.formula_mode == FORMULA_PED) begin
         ped16 = ped16 - {{(DIFF_W-15){ped_adj[14]}}, ped_adj};
      end
      sum16   = {{(DIFF_W-SUM_BITS-4){1'b0}}, req_patch_sum, 4'd0};
      diff16  = $signed(sum16 - ped16);
      sigma16 = $signed({{(DIFF_W-12){1'b0}}, cfg.sigma_threshold, 4'd0});
   end

   // classify: forced zero, saturate on zero scale, else divide
   always_comb begin
      item_in.diff_pos = diff16[DIFF_W-2:0];
      item_in.scale16  = scale16;
      item_in.zero     = diff16[DIFF_W-1] | (diff16 == '0) | (diff16 < sigma16);
      item_in.sat      = (scale16 == '0);
      valid_in         = take | (valid_ff & ~item_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

>>> src/tplv_queue.sv
module tplv_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  tplv_pkg::item_type    push_item,
   output logic                  push_ready,
   output logic                  pop_valid,
   output tplv_pkg::item_type    pop_item,
   input  logic                  pop_ready
);
   import tplv_pkg::*;

   item_type   entry_ff [0:1];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> src/tplv_back.sv
module tplv_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  tplv_pkg::item_type    item,
   output logic                  item_ready,
   output logic                  rsp_strobe,
   output logic [5:0]            rsp_lut_value
);
   import tplv_pkg::*;

   // stage 0 forms the rounding fraction; stages 1..QUO_BITS resolve one quotient bit each
   logic [CMP_W-1:0]    rem_ff   [0:QUO_BITS];
   logic [DEN_W-1:0]    den_ff   [0:QUO_BITS];
   logic [QUO_BITS-1:0] quo_ff   [0:QUO_BITS];
   logic [0:QUO_BITS]   valid_ff;
   logic [0:QUO_BITS]   zero_ff;
   logic [0:QUO_BITS]   sat_ff;
   logic [0:QUO_BITS]   hi_ff;
   logic [CMP_W-1:0]    rem_in   [1:QUO_BITS];
   logic [QUO_BITS-1:0] quo_in   [1:QUO_BITS];
   logic [CMP_W-1:0]    step_den [1:QUO_BITS];
   logic [NUM_W-1:0]    num0;
   logic [DEN_W-1:0]    den0;
   logic [CMP_W-1:0]    den_top;
   logic                hi0;
   logic                out_strobe_ff;
   logic [5:0]          out_value_ff, out_value_in;
   logic [QUO_BITS-1:0] quo_last;

   assign item_ready    = 1'b1;
   assign rsp_strobe    = out_strobe_ff;
   assign rsp_lut_value = out_value_ff;

   // numerator 2*diff + scale, denominator 2*scale, quotient overflow check
   always_comb begin
      num0    = {1'b0, item.diff_pos, 1'b0} + NUM_W'(item.scale16);
      den0    = {item.scale16, 1'b0};
      den_top = CMP_W'({den0, {QUO_BITS{1'b0}}});
      hi0     = (CMP_W'(num0) >= den_top);
   end

   // restoring division steps
   always_comb begin
      for (int i = 1; i <= QUO_BITS; i++) begin
         step_den[i] = CMP_W'(den_ff[i-1]) << (QUO_BITS - i);
         if (rem_ff[i-1] >= step_den[i]) begin
            rem_in[i] = rem_ff[i-1] - step_den[i];
            quo_in[i] = quo_ff[i-1] | (QUO_BITS'(1) << (QUO_BITS - i));
         end else begin
            rem_in[i] = rem_ff[i-1];
            quo_in[i] = quo_ff[i-1];
         end
      end
   end

   // pick forced zero, saturation or clamped quotient
   always_comb begin
      quo_last = quo_ff[QUO_BITS];
      if (zero_ff[QUO_BITS]) begin
         out_value_in = 6'd0;
      end else if (sat_ff[QUO_BITS] | hi_ff[QUO_BITS]) begin
         out_value_in = LUT_MAX;
      end else if (6'(quo_last) > LUT_MAX) begin
         out_value_in = LUT_MAX;
      end else begin
         out_value_in = 6'(quo_last);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         out_strobe_ff <= 1'b0;
      end else begin
         valid_ff[0]   <= item_valid;
         for (int i = 1; i <= QUO_BITS; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
         out_strobe_ff <= valid_ff[QUO_BITS];
      end
      rem_ff[0]  <= CMP_W'(num0);
      den_ff[0]  <= den0;
      quo_ff[0]  <= '0;
      zero_ff[0] <= item.zero;
      sat_ff[0]  <= item.sat;
      hi_ff[0]   <= hi0;
      for (int i = 1; i <= QUO_BITS; i++) begin
         rem_ff[i]  <= rem_in[i];
         den_ff[i]  <= den_ff[i-1];
         quo_ff[i]  <= quo_in[i];
         zero_ff[i] <= zero_ff[i-1];
         sat_ff[i]  <= sat_ff[i-1];
         hi_ff[i]   <= hi_ff[i-1];
      end
      out_value_ff <= out_value_in;
   end

endmodule

>>> src/trigger_patch_lut_value_top.sv
// Trigger patch lookup value. One patch sum is taken on every clock edge with
// start high and busy low, and the 6-bit lookup value comes out on
// rsp_lut_value with rsp_strobe high for exactly one cycle, in order. The
// receiver cannot stall: results must be taken when strobed. A new sum may be
// given every cycle; busy stays low in steady operation because the divider
// pipeline (one quotient bit per stage, six stages) takes an item each cycle
// and the two-entry queue between the classifying front stage and the divider
// never fills. The user must write configuration registers through the
// APB-style port only while no sum is in flight; the block does not check it.
module trigger_patch_lut_value_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [tplv_pkg::SUM_BITS-1:0]     req_patch_sum,
   output logic                              rsp_strobe,
   output logic [5:0]                        rsp_lut_value,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [tplv_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import tplv_pkg::*;

   cfg_type  cfg;
   item_type front_item;
   item_type queue_item;
   logic     front_valid;
   logic     queue_ready;
   logic     queue_valid;
   logic     back_ready;

   // configuration registers
   tplv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // scale, pedestal and classification
   tplv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_patch_sum (req_patch_sum),
      .cfg           (cfg),
      .item_valid    (front_valid),
      .item          (front_item),
      .item_ready    (queue_ready)
   );

   // decoupling queue
   tplv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_item  (front_item),
      .push_ready (queue_ready),
      .pop_valid  (queue_valid),
      .pop_item   (queue_item),
      .pop_ready  (back_ready)
   );

   // pipelined rounding divide and clamp
   tplv_back u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (queue_valid),
      .item          (queue_item),
      .item_ready    (back_ready),
      .rsp_strobe    (rsp_strobe),
      .rsp_lut_value (rsp_lut_value)
   );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import tplv_pkg::*;

   localparam int POWERUP_COUNTS = 15;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_PHASES  = 30;
   localparam int ITEMS_PER_PHASE = 52;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [SUM_BITS-1:0]    req_patch_sum = '0;
   logic                   rsp_strobe;
   logic [5:0]             rsp_lut_value;
   logic                   psel = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  paddr = '0;
   logic [31:0]            pwdata = '0;
   logic [31:0]            prdata;
   logic                   pready;

   // predicted lookup values, oldest first
   logic [5:0] lut_expect_q[$];
   // our copy of the block's registers
   cfg_type    csr_shadow;
   int         fail_count = 0;
   int         burst_left = 0;
   int         idle_cycles = 0;

   trigger_patch_lut_value_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_patch_sum (req_patch_sum),
      .rsp_strobe    (rsp_strobe),
      .rsp_lut_value (rsp_lut_value),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_failure(input string what, input int expected_val, input int actual_val);
      fail_count++;
      if (fail_count <= 10) begin
         $display("mismatch at %0t: %s expected %0d actual %0d",
                  $realtime, what, expected_val, actual_val);
      end
   endtask

   // lookup value from pedestal and scale in sixteenths of a count, exact rational with half-up rounding
   function automatic logic [5:0] predict_lut_value(input cfg_type c,
                                                    input logic [SUM_BITS-1:0] sum_value);
      int masked;
      int scale16;
      int ped16;
      int diff16;
      int quotient;
      logic [5:0] lut;
      masked = (c.masked_towers > 5'd16) ? 16 : int'(c.masked_towers);
      if (c.formula_mode == FORMULA_SCALE) begin
         scale16 = (masked != 16) ? int'(c.base_scale) * (16 - masked) : 16;
      end else begin
         scale16 = int'(c.base_scale) * 16;
      end
      ped16 = int'(c.base_pedestal) * 16;
      if (c.powerup_offset_on) begin
         ped16 += POWERUP_COUNTS * 16;
      end
      if (c.formula_mode == FORMULA_PED) begin
         ped16 -= masked * (int'(c.pedestal_shift) - 8);
      end
      diff16 = int'(sum_value) * 16 - ped16;
      if (diff16 <= 0) begin
         lut = '0;
      end else if (scale16 == 0) begin
         lut = LUT_MAX;
      end else begin
         quotient = (2 * diff16 + scale16) / (2 * scale16);
         lut = (quotient > int'(LUT_MAX)) ? LUT_MAX : quotient[5:0];
      end
      if (diff16 < int'(c.sigma_threshold) * 16) begin
         lut = '0;
      end
      return lut;
   endfunction

   function automatic logic [31:0] register_value(input reg_index_type idx);
      case (idx)
         REG_FORMULA:  return 32'(csr_shadow.formula_mode);
         REG_SCALE:    return 32'(csr_shadow.base_scale);
         REG_PEDESTAL: return 32'(csr_shadow.base_pedestal);
         REG_SIGMA:    return 32'(csr_shadow.sigma_threshold);
         REG_POWERUP:  return 32'(csr_shadow.powerup_offset_on);
         REG_MASKED:   return 32'(csr_shadow.masked_towers);
         REG_SHIFT:    return 32'(csr_shadow.pedestal_shift);
         default:      return '0;
      endcase
   endfunction

   // one sum transfer, with a random gap or a gap-free burst ahead of it
   task automatic send_sum(input logic [SUM_BITS-1:0] sum_value);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else if ($urandom_range(0, 7) == 0) begin
         burst_left = $urandom_range(4, 40);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 13);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_patch_sum <= sum_value;
      do @(posedge clock); while (busy);
      lut_expect_q.push_back(predict_lut_value(csr_shadow, sum_value));
   endtask

   // stop sending and let every predicted result come back
   task automatic wait_for_idle();
      start <= 1'b0;
      do @(posedge clock); while (lut_expect_q.size() != 0);
   endtask

   // setup then access phase; back-to-back transfers keep psel high
   task automatic csr_transfer(input logic is_write, input reg_index_type idx,
                               input logic [31:0] data, output logic [31:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= CSR_ADDR_W'({idx, 2'b00});
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
   endtask

   task automatic write_register(input reg_index_type idx, input logic [31:0] data);
      logic [31:0] unused_rd;
      csr_transfer(1'b1, idx, data, unused_rd);
      case (idx)
         REG_FORMULA:  csr_shadow.formula_mode      = data[1:0];
         REG_SCALE:    csr_shadow.base_scale        = data[7:0];
         REG_PEDESTAL: csr_shadow.base_pedestal     = data[9:0];
         REG_SIGMA:    csr_shadow.sigma_threshold   = data[7:0];
         REG_POWERUP:  csr_shadow.powerup_offset_on = data[0];
         REG_MASKED:   csr_shadow.masked_towers     = data[4:0];
         REG_SHIFT:    csr_shadow.pedestal_shift    = data[7:0];
         default: ;
      endcase
   endtask

   task automatic check_all_registers();
      logic [31:0] rd;
      for (int i = 0; i < 7; i++) begin
         csr_transfer(1'b0, reg_index_type'(i), $urandom, rd);
         if (rd !== register_value(reg_index_type'(i))) begin
            flag_failure($sformatf("register %0d readback", i),
                         int'(register_value(reg_index_type'(i))), int'(rd));
         end
      end
   endtask

   // write every register (junk in the unused upper bits), read all back
   task automatic load_settings(input cfg_type c, input bit poke_unused);
      logic [31:0] data;
      wait_for_idle();
      for (int i = 0; i < 7; i++) begin
         data = $urandom;
         case (reg_index_type'(i))
            REG_FORMULA:  data[1:0] = c.formula_mode;
            REG_SCALE:    data[7:0] = c.base_scale;
            REG_PEDESTAL: data[9:0] = c.base_pedestal;
            REG_SIGMA:    data[7:0] = c.sigma_threshold;
            REG_POWERUP:  data[0]   = c.powerup_offset_on;
            REG_MASKED:   data[4:0] = c.masked_towers;
            REG_SHIFT:    data[7:0] = c.pedestal_shift;
            default: ;
         endcase
         write_register(reg_index_type'(i), data);
      end
      if (poke_unused) begin
         write_register(REG_UNUSED, $urandom);
      end
      check_all_registers();
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic cfg_type random_settings();
      cfg_type c;
      c.formula_mode = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
         0: c.base_scale = 8'd0;
         1: c.base_scale = 8'd255;
         2: c.base_scale = 8'($urandom_range(1, 255));
         default: c.base_scale = 8'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 3))
         0: c.base_pedestal = 10'd0;
         1: c.base_pedestal = 10'd1023;
         default: c.base_pedestal = 10'($urandom_range(0, 1023));
      endcase
      case ($urandom_range(0, 3))
         0: c.sigma_threshold = 8'd255;
         1: c.sigma_threshold = 8'($urandom_range(0, 40));
         default: c.sigma_threshold = 8'd0;
      endcase
      c.powerup_offset_on = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: c.masked_towers = 5'd0;
         1: c.masked_towers = 5'd16;
         2: c.masked_towers = 5'd31;
         default: c.masked_towers = 5'($urandom_range(0, 31));
      endcase
      case ($urandom_range(0, 5))
         0: c.pedestal_shift = 8'd0;
         1: c.pedestal_shift = 8'd7;
         2: c.pedestal_shift = 8'd8;
         3: c.pedestal_shift = 8'd255;
         default: c.pedestal_shift = 8'($urandom_range(0, 255));
      endcase
      return c;
   endfunction

   // mostly sums around the pedestal, so results sweep 0..62 and the sigma edge
   function automatic logic [SUM_BITS-1:0] shaped_sum(input cfg_type c);
      int ped_counts;
      int span;
      int value;
      ped_counts = int'(c.base_pedestal) + (c.powerup_offset_on ? POWERUP_COUNTS : 0);
      span = ((c.base_scale == 0) ? 1 : int'(c.base_scale)) * 70 + 8;
      case ($urandom_range(0, 9))
         0, 1: value = $urandom_range(0, (1 << SUM_BITS) - 1);
         2: value = $urandom_range(0, 1) ? (1 << SUM_BITS) - 1 : 0;
         default: value = ped_counts - 4 + $urandom_range(0, span);
      endcase
      if (value < 0) value = 0;
      if (value > (1 << SUM_BITS) - 1) value = (1 << SUM_BITS) - 1;
      return value[SUM_BITS-1:0];
   endfunction

   // result checking
   always @(posedge clock) begin
      logic [5:0] expected_lut;
      if (!reset && rsp_strobe) begin
         if (lut_expect_q.size() == 0) begin
            flag_failure("unexpected lut_value transfer", -1, int'(rsp_lut_value));
         end else begin
            expected_lut = lut_expect_q.pop_front();
            if (rsp_lut_value !== expected_lut) begin
               flag_failure("lut_value", int'(expected_lut), int'(rsp_lut_value));
            end
         end
      end
   end

   // watchdog: cycles with no transfer on any port
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog expired at %0t", $realtime);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // reset values, read back, then sums with unit scale and zero pedestal
   task automatic test_reset_values();
      check_all_registers();
      psel <= 1'b0;
      penable <= 1'b0;
      send_sum('0);
      send_sum(12'd1);
      send_sum(12'd62);
      send_sum(12'd63);
      send_sum('1);
   endtask

   task automatic test_formula_modes();
      cfg_type c;
      for (int f = 0; f < 4; f++) begin
         c = '0;
         c.formula_mode = 2'(f);
         c.base_scale = 8'd4;
         c.base_pedestal = 10'd100;
         c.masked_towers = 5'd8;
         c.pedestal_shift = 8'd40;
         load_settings(c, 1'b0);
         send_sum(12'hAAA);
         send_sum(12'd230);
      end
   endtask

   task automatic test_special_settings();
      cfg_type c;
      // masked count saturates, all towers masked gives unit scale
      c = '0;
      c.formula_mode = FORMULA_SCALE;
      c.base_scale = 8'd3;
      c.masked_towers = 5'd31;
      load_settings(c, 1'b0);
      send_sum(12'd50);
      // zero scale: positive difference saturates, zero difference gives zero
      c = '0;
      c.base_pedestal = 10'd200;
      load_settings(c, 1'b0);
      send_sum(12'd201);
      send_sum(12'd200);
      // shift below eight raises the pedestal in formula 2
      c = '0;
      c.formula_mode = FORMULA_PED;
      c.base_scale = 8'd1;
      c.base_pedestal = 10'd10;
      c.masked_towers = 5'd16;
      c.pedestal_shift = 8'd0;
      load_settings(c, 1'b0);
      send_sum(12'd18);
      send_sum(12'd19);
      // sigma at its maximum
      c = '0;
      c.base_scale = 8'd1;
      c.sigma_threshold = 8'd255;
      load_settings(c, 1'b0);
      send_sum(12'd254);
      send_sum(12'd255);
      // powerup offset on top of the largest pedestal, zero and positive differences
      c = '0;
      c.base_scale = 8'd255;
      c.base_pedestal = 10'd1023;
      c.powerup_offset_on = 1'b1;
      load_settings(c, 1'b0);
      send_sum(12'h555);
      send_sum(12'd1038);
      send_sum('1);
      // write to the unused address leaves the registers alone
      load_settings(c, 1'b1);
      send_sum(12'd2000);
   endtask

   task automatic test_random_traffic();
      cfg_type c;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            c = '0;
         end else if (phase == 1) begin
            c = '1;
         end else begin
            c = random_settings();
         end
         load_settings(c, ($urandom_range(0, 4) == 0));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_sum(shaped_sum(c));
         end
      end
   endtask

   initial begin
      csr_shadow = '0;
      csr_shadow.base_scale = 8'd1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_formula_modes();
      test_special_settings();
      test_random_traffic();

      wait_for_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      foreach (lut_expect_q[i]) begin
         flag_failure("lut_value never arrived", int'(lut_expect_q[i]), -1);
      end
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/tplv_pkg.sv
src/tplv_csr.sv
src/tplv_front.sv
src/tplv_queue.sv
src/tplv_back.sv
src/trigger_patch_lut_value_top.sv
bench/testbench.sv
